// ===== hw/rtl/ptt_pkg.sv =====
// Package for the pressure trend tracker: sizes, field widths, codes,
// state encoding and the ring pointer helper. No dependencies.
`timescale 1ns / 1ps

package ptt_pkg;

    // History ring geometry.
    localparam int HIST_DEPTH  = 64;
    localparam int PTR_W       = $clog2(HIST_DEPTH);
    localparam int FILL_W      = $clog2(HIST_DEPTH + 1);
    localparam int MIN_SAMPLES = 5;

    // Field widths.
    localparam int PA_W     = 17;
    localparam int TIME_W   = 48;
    localparam int MS_W     = 30;
    localparam int THR_W    = 14;
    localparam int TUS_W    = 40;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;

    localparam logic [TUS_W-1:0] US_PER_MS = TUS_W'(1000);

    // Operation codes.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Trend codes.
    localparam logic [1:0] TREND_UNAVAIL = 2'd0;
    localparam logic [1:0] TREND_FALLING = 2'd1;
    localparam logic [1:0] TREND_STABLE  = 2'd2;
    localparam logic [1:0] TREND_RISING  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH   = CFG_IDX_W'(3);

    typedef struct packed {
        logic [TIME_W-1:0] time_us;
        logic [PA_W-1:0]   pa;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LAST,
        S_EVICT,
        S_STORE,
        S_RD_A,
        S_RD_B,
        S_RD_C,
        S_CALC,
        S_DONE
    } t_state;

    // Physical slot of position off counted from base, with wrap.
    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] base,
                                                 input logic [FILL_W-1:0] off);
        logic [FILL_W:0] sum;
        sum = (FILL_W+1)'(base) + (FILL_W+1)'(off);
        if (sum >= (FILL_W+1)'(HIST_DEPTH)) begin
            sum = sum - (FILL_W+1)'(HIST_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/ptt_if.sv =====
// Channel interfaces of the pressure trend tracker: sample input,
// result output and configuration write. Depends on ptt_pkg.
`timescale 1ns / 1ps

interface ptt_in_if;
    import ptt_pkg::*;
    logic              valid;
    logic              ready;
    logic              op;
    logic              pressure_ok;
    logic [PA_W-1:0]   pressure_pa;
    logic [TIME_W-1:0] now_time_us;
    modport source(output valid, op, pressure_ok, pressure_pa, now_time_us, input ready);
    modport sink(input valid, op, pressure_ok, pressure_pa, now_time_us, output ready);
endinterface

interface ptt_out_if;
    import ptt_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        trend;
    logic              sample_stored;
    logic [FILL_W-1:0] history_fill;
    modport source(output valid, trend, sample_stored, history_fill, input ready);
    modport sink(input valid, trend, sample_stored, history_fill, output ready);
endinterface

interface ptt_cfg_if;
    import ptt_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== hw/rtl/pressure_trend_tracker.sv =====
// Pressure trend tracker: timestamped history ring in one synchronous RAM,
// eviction by window, and rising/falling/stable trend. Depends on ptt_pkg, ptt_if.
// Sequence: last-entry read, eviction of each expired head entry, store, three reads and
// the trend calculation; fewer than five held samples end it at the store, an empty history
// skips the last-entry read, a skipped sample ends there and a clear or invalid one at once.
// Throughput: one item at a time; the next transfer is taken the cycle after the result
// register loads, and a result still waiting in that register holds the sequencer.
// Reset (synchronous, active low) empties the history, sets the trend unavailable
// and loads the register defaults; the RAM contents are not cleared.
`timescale 1ns / 1ps

module pressure_trend_tracker (
    input  logic i_clk,
    input  logic i_rst_n,
    ptt_in_if.sink    i_in,
    ptt_cfg_if.sink   i_cfg,
    ptt_out_if.source o_out
);
    import ptt_pkg::*;

    t_state            r_state, n_state;
    logic [PTR_W-1:0]  r_head, n_head;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [1:0]        r_held, n_held;
    logic              r_stored, n_stored;
    logic [PA_W-1:0]   r_pa, n_pa;
    logic [TIME_W-1:0] r_now, n_now;
    logic [TIME_W-1:0] r_t0, n_t0;
    logic [PA_W-1:0]   r_p0, n_p0;
    logic [PA_W:0]     r_old_sum, n_old_sum;

    logic              r_out_valid, n_out_valid;
    logic [1:0]        r_out_trend, n_out_trend;
    logic              r_out_stored, n_out_stored;
    logic [FILL_W-1:0] r_out_fill, n_out_fill;

    logic [TUS_W-1:0]  r_interval_us;
    logic [TUS_W-1:0]  r_window_us;
    logic [TUS_W-1:0]  r_span_us;
    logic [THR_W-1:0]  r_thresh;
    logic [TUS_W-1:0]  cfg_us;

    t_entry            r_mem [HIST_DEPTH];
    t_entry            r_rd;
    logic [PTR_W-1:0]  mem_ra;
    logic [PTR_W-1:0]  mem_wa;
    logic              mem_we;
    t_entry            mem_wd;

    logic              in_xfer;
    logic [TIME_W:0]   last_gap;
    logic              skip;
    logic              evict;
    logic [PTR_W-1:0]  head_inc;
    logic [PTR_W-1:0]  st_head;
    logic [FILL_W-1:0] st_fill;
    logic [FILL_W-1:0] st_fill_new;
    logic              span_short;
    logic [PA_W:0]     new_sum;
    logic signed [PA_W+2:0] diff;
    logic signed [PA_W+2:0] lim;

    assign in_xfer    = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid         = r_out_valid;
    assign o_out.trend         = r_out_trend;
    assign o_out.sample_stored = r_out_stored;
    assign o_out.history_fill  = r_out_fill;

    // Register values are kept in microseconds so the datapath compares directly.
    assign cfg_us = TUS_W'(i_cfg.data[MS_W-1:0]) * US_PER_MS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval_us <= TUS_W'(64'd60000000);
            r_window_us   <= TUS_W'(64'd10800000000);
            r_span_us     <= TUS_W'(64'd3600000000);
            r_thresh      <= THR_W'(100);
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_INTERVAL: r_interval_us <= cfg_us;
                CFG_WINDOW:   r_window_us   <= cfg_us;
                CFG_SPAN:     r_span_us     <= cfg_us;
                CFG_THRESH:   r_thresh      <= i_cfg.data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // History RAM with one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[mem_ra];
    end

    // Datapath terms used by the sequencer.
    assign last_gap = {1'b0, r_now} - {1'b0, r_rd.time_us};
    assign skip     = last_gap[TIME_W] ||
                      (last_gap[TIME_W-1:0] < TIME_W'(r_interval_us));
    assign evict    = (r_fill != '0) &&
                      (({1'b0, r_rd.time_us} + (TIME_W+1)'(r_window_us)) < {1'b0, r_now});
    assign head_inc = ptr_add(r_head, FILL_W'(1));

    always_comb begin
        if (r_fill == FILL_W'(HIST_DEPTH)) begin
            st_head = head_inc;
            st_fill = FILL_W'(HIST_DEPTH - 1);
        end else begin
            st_head = r_head;
            st_fill = r_fill;
        end
    end
    assign st_fill_new = st_fill + FILL_W'(1);

    assign span_short = {1'b0, r_now} < ({1'b0, r_t0} + (TIME_W+1)'(r_span_us));
    assign new_sum    = (PA_W+1)'(r_rd.pa) + (PA_W+1)'(r_pa);
    assign diff       = (PA_W+3)'(new_sum) - (PA_W+3)'(r_old_sum);
    assign lim        = (PA_W+3)'({r_thresh, 1'b0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_fill      <= '0;
            r_held      <= TREND_UNAVAIL;
            r_stored    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_held      <= n_held;
            r_stored    <= n_stored;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pa         <= n_pa;
        r_now        <= n_now;
        r_t0         <= n_t0;
        r_p0         <= n_p0;
        r_old_sum    <= n_old_sum;
        r_out_trend  <= n_out_trend;
        r_out_stored <= n_out_stored;
        r_out_fill   <= n_out_fill;
    end

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_fill       = r_fill;
        n_held       = r_held;
        n_stored     = r_stored;
        n_pa         = r_pa;
        n_now        = r_now;
        n_t0         = r_t0;
        n_p0         = r_p0;
        n_old_sum    = r_old_sum;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_trend  = r_out_trend;
        n_out_stored = r_out_stored;
        n_out_fill   = r_out_fill;
        mem_ra       = r_head;
        mem_we       = 1'b0;
        mem_wa       = ptr_add(st_head, st_fill);
        mem_wd       = '{time_us: r_now, pa: r_pa};

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_now    = i_in.now_time_us;
                    n_pa     = i_in.pressure_pa;
                    n_stored = 1'b0;
                    if (i_in.op == OP_CLEAR) begin
                        n_head  = '0;
                        n_fill  = '0;
                        n_state = S_DONE;
                    end else if (!i_in.pressure_ok) begin
                        n_held  = TREND_UNAVAIL;
                        n_state = S_DONE;
                    end else if (r_fill == '0) begin
                        // Nothing to compare with or evict; the eviction test sees fill zero.
                        n_state = S_EVICT;
                    end else begin
                        mem_ra  = ptr_add(r_head, r_fill - FILL_W'(1));
                        n_state = S_LAST;
                    end
                end
            end
            S_LAST: begin
                if (skip) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_EVICT;
                end
            end
            S_EVICT: begin
                // One head entry is tested per cycle; the next head is read meanwhile.
                if (evict) begin
                    n_head = head_inc;
                    n_fill = r_fill - FILL_W'(1);
                    mem_ra = head_inc;
                end else begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                mem_we   = 1'b1;
                n_head   = st_head;
                n_fill   = st_fill_new;
                n_stored = 1'b1;
                if (st_fill_new < FILL_W'(MIN_SAMPLES)) begin
                    n_held  = TREND_UNAVAIL;
                    n_state = S_DONE;
                end else begin
                    n_state = S_RD_A;
                end
            end
            S_RD_A: begin
                mem_ra  = r_head;
                n_state = S_RD_B;
            end
            S_RD_B: begin
                n_t0    = r_rd.time_us;
                n_p0    = r_rd.pa;
                mem_ra  = head_inc;
                n_state = S_RD_C;
            end
            S_RD_C: begin
                n_old_sum = (PA_W+1)'(r_p0) + (PA_W+1)'(r_rd.pa);
                mem_ra    = ptr_add(r_head, r_fill - FILL_W'(2));
                n_state   = S_CALC;
            end
            S_CALC: begin
                if (span_short) begin
                    n_held = TREND_UNAVAIL;
                end else if (diff > lim) begin
                    n_held = TREND_RISING;
                end else if (diff < -lim) begin
                    n_held = TREND_FALLING;
                end else begin
                    n_held = TREND_STABLE;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_trend  = r_held;
                    n_out_stored = r_stored;
                    n_out_fill   = r_fill;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
